/* sv/ffha_pkg.sv */
package ffha_pkg;
   localparam int unsigned HeapBytes   = 16777216;
   localparam int unsigned AlignBytes  = 8;
   localparam int unsigned HeaderBytes = 12;
   localparam int unsigned MaxBlocks   = 64;
   localparam int unsigned IdxW        = $clog2(MaxBlocks);
   localparam int unsigned CntW        = $clog2(MaxBlocks + 1);
   localparam int unsigned OffW        = 24;
   localparam int unsigned SizeW       = 25;

   localparam logic [2:0] ST_ALLOC   = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_ZERO    = 3'd2;
   localparam logic [2:0] ST_FREED   = 3'd3;
   localparam logic [2:0] ST_IGNORED = 3'd4;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic [OffW-1:0]  start;
      logic [SizeW-1:0] size;
      logic             free;
   } entry_type;

   localparam int unsigned EntryW = $bits(entry_type);

   typedef struct packed {
      logic [0:0]  req_type;
      logic [31:0] req_size;
      logic [23:0] free_offset;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [23:0] grant_offset;
   } rsp_type;
endpackage

/* sv/ffha_if.sv */
interface ffha_req_if;
   logic                  valid;
   logic                  ready;
   ffha_pkg::req_type_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ffha_rsp_if;
   logic              valid;
   logic              ready;
   ffha_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/first_fit_heap_allocator.sv */
// One transaction at a time. The block table lives in a single-port-read
// RAM of MaxBlocks entries; each step reads one entry and may write one.
// An allocate walks forward to the first fit, and when it splits it shifts
// the tail up one entry per cycle. A free walks to the matching entry,
// then compacts the table in one forward pass that merges free runs, one
// entry per cycle. After reset an initialising state writes the first
// entry before the first request.
module first_fit_heap_allocator (
   input  logic             clock,
   input  logic             reset,
   ffha_req_if.sink         req,
   ffha_rsp_if.source       rsp,
   input  logic             csr_wr_en,
   input  logic [12:0]      csr_wr_data
);
   typedef enum logic [8:0] {
      S_INIT  = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_SCAN  = 9'b000000100,
      S_SHIFT = 9'b000001000,
      S_PUTA  = 9'b000010000,
      S_MERGE = 9'b000100000,
      S_MFLSH = 9'b001000000,
      S_RESP  = 9'b010000000,
      S_FIND  = 9'b100000000
   } state_type;

   localparam logic [ffha_pkg::SizeW-1:0] HdrS = ffha_pkg::SizeW'(ffha_pkg::HeaderBytes);

   state_type state_ff, state_in;
   logic [12:0] split_min_ff;
   logic [ffha_pkg::CntW-1:0] count_ff, count_in;
   logic [ffha_pkg::CntW-1:0] idx_ff, idx_in;   // entry being read (address)
   logic [ffha_pkg::CntW-1:0] wptr_ff, wptr_in; // write index during merge
   logic rd_pend_ff, rd_pend_in;
   logic [ffha_pkg::SizeW-1:0] need_ff, need_in;
   logic [ffha_pkg::OffW-1:0] off_ff, off_in;
   ffha_pkg::entry_type carry_ff, carry_in; // pending entry for merge
   logic carry_v_ff, carry_v_in;
   ffha_pkg::entry_type split_ff, split_in;
   logic [ffha_pkg::CntW-1:0] split_at_ff, split_at_in;
   ffha_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_v_ff, rsp_v_in;

   logic we;
   logic [ffha_pkg::IdxW-1:0] wa, ra;
   ffha_pkg::entry_type wd, rd;
   logic [ffha_pkg::EntryW-1:0] rd_raw;

   assign rd = ffha_pkg::entry_type'(rd_raw);

   ffha_ram #(.Depth(ffha_pkg::MaxBlocks), .Width(ffha_pkg::EntryW)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (ffha_pkg::EntryW'(wd)),
      .rd_addr (ra),
      .rd_data (rd_raw)
   );

   logic [32:0] rounded;
   logic [ffha_pkg::SizeW+13:0] split_lim;
   logic [ffha_pkg::SizeW-1:0] leftover;
   logic last;

   assign req.ready   = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp.valid   = rsp_v_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      rounded   = ({1'b0, req.payload.req_size} + 33'(ffha_pkg::AlignBytes - 1))
                  / 33'(ffha_pkg::AlignBytes) * 33'(ffha_pkg::AlignBytes);
      split_lim = (ffha_pkg::SizeW+14)'(need_ff) + (ffha_pkg::SizeW+14)'(HdrS)
                  + (ffha_pkg::SizeW+14)'(split_min_ff);
      leftover  = rd.size - need_ff - HdrS;
      last      = (idx_ff + 1'b1 >= count_ff);
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      wptr_in     = wptr_ff;
      rd_pend_in  = 1'b0;
      need_in     = need_ff;
      off_in      = off_ff;
      carry_in    = carry_ff;
      carry_v_in  = carry_v_ff;
      split_in    = split_ff;
      split_at_in = split_at_ff;
      rsp_in      = rsp_ff;
      rsp_v_in    = rsp_v_ff && !rsp.ready;
      we = 1'b0;
      wa = idx_ff[ffha_pkg::IdxW-1:0];
      wd = rd;
      ra = idx_ff[ffha_pkg::IdxW-1:0];
      case (state_ff)
         S_INIT: begin
            we = 1'b1;
            wa = '0;
            wd.start = '0;
            wd.size  = ffha_pkg::SizeW'(ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes);
            wd.free  = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            idx_in = '0;
            ra = '0;
            if (req.valid && req.ready) begin
               off_in = req.payload.free_offset;
               need_in = ffha_pkg::SizeW'(rounded);
               rsp_in.grant_offset = '0;
               if (req.payload.req_type == ffha_pkg::REQ_ALLOC &&
                   req.payload.req_size == '0) begin
                  rsp_in.status = ffha_pkg::ST_ZERO;
                  state_in = S_RESP;
               end else if (req.payload.req_type == ffha_pkg::REQ_ALLOC &&
                            req.payload.req_size > 32'(ffha_pkg::HeapBytes)) begin
                  rsp_in.status = ffha_pkg::ST_NOFIT;
                  state_in = S_RESP;
               end else begin
                  rd_pend_in = 1'b1;
                  state_in = (req.payload.req_type == ffha_pkg::REQ_ALLOC) ? S_SCAN : S_FIND;
               end
            end
         end
         S_SCAN: begin
            if (rd_pend_ff) begin
               if (rd.free && rd.size >= need_ff) begin
                  rsp_in.status = ffha_pkg::ST_ALLOC;
                  rsp_in.grant_offset = rd.start + ffha_pkg::OffW'(ffha_pkg::HeaderBytes);
                  we = 1'b1;
                  wd.free = 1'b0;
                  if (count_ff < ffha_pkg::CntW'(ffha_pkg::MaxBlocks) &&
                      (ffha_pkg::SizeW+14)'(rd.size) > split_lim) begin
                     wd.size = need_ff;
                     split_in.start = rd.start + ffha_pkg::OffW'(need_ff)
                                      + ffha_pkg::OffW'(ffha_pkg::HeaderBytes);
                     split_in.size  = leftover;
                     split_in.free  = 1'b1;
                     split_at_in = idx_ff + 1'b1;
                     // Shift from the top down to make room.
                     idx_in = count_ff - 1'b1;
                     ra = count_in[ffha_pkg::IdxW-1:0] - 1'b1;
                     rd_pend_in = 1'b1;
                     state_in = S_SHIFT;
                  end else begin
                     state_in = S_RESP;
                  end
               end else if (last) begin
                  rsp_in.status = ffha_pkg::ST_NOFIT;
                  rsp_in.grant_offset = '0;
                  state_in = S_RESP;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  ra = idx_in[ffha_pkg::IdxW-1:0];
                  rd_pend_in = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            if (idx_ff < split_at_ff) begin
               state_in = S_PUTA;
            end else if (rd_pend_ff) begin
               we = 1'b1;
               wa = ffha_pkg::IdxW'(idx_ff + 1'b1);
               wd = rd;
               idx_in = idx_ff - 1'b1;
               ra = idx_in[ffha_pkg::IdxW-1:0];
               rd_pend_in = 1'b1;
            end
         end
         S_PUTA: begin
            we = 1'b1;
            wa = split_at_ff[ffha_pkg::IdxW-1:0];
            wd = split_ff;
            count_in = count_ff + 1'b1;
            state_in = S_RESP;
         end
         S_FIND: begin
            if (rd_pend_ff) begin
               if (rd.start + ffha_pkg::OffW'(ffha_pkg::HeaderBytes) == off_ff &&
                   {1'b0, rd.start} + 25'(ffha_pkg::HeaderBytes) < 25'(1 << 24)) begin
                  rsp_in.grant_offset = '0;
                  if (!rd.free) begin
                     rsp_in.status = ffha_pkg::ST_FREED;
                     we = 1'b1;
                     wd.free = 1'b1;
                     // Compaction pass over the whole table from entry 0.
                     idx_in = '0;
                     ra = '0;
                     wptr_in = '0;
                     carry_v_in = 1'b0;
                     rd_pend_in = 1'b1;
                     state_in = S_MERGE;
                  end else begin
                     rsp_in.status = ffha_pkg::ST_IGNORED;
                     state_in = S_RESP;
                  end
               end else if (last) begin
                  rsp_in.status = ffha_pkg::ST_IGNORED;
                  rsp_in.grant_offset = '0;
                  state_in = S_RESP;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  ra = idx_in[ffha_pkg::IdxW-1:0];
                  rd_pend_in = 1'b1;
               end
            end
         end
         S_MERGE: begin
            // The freed entry's write lands at the edge of the first read, so
            // that read may be stale; the first cycle here reads entry 0 again.
            if (rd_pend_ff) begin
               if (carry_v_ff && carry_ff.free && rd.free) begin
                  carry_in.size = carry_ff.size + HdrS + rd.size;
               end else begin
                  if (carry_v_ff) begin
                     we = 1'b1;
                     wa = wptr_ff[ffha_pkg::IdxW-1:0];
                     wd = carry_ff;
                     wptr_in = wptr_ff + 1'b1;
                  end
                  carry_in = rd;
                  carry_v_in = 1'b1;
               end
               if (last) begin
                  state_in = S_MFLSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  ra = idx_in[ffha_pkg::IdxW-1:0];
                  rd_pend_in = 1'b1;
               end
            end else begin
               rd_pend_in = 1'b1;
            end
         end
         S_MFLSH: begin
            we = 1'b1;
            wa = wptr_ff[ffha_pkg::IdxW-1:0];
            wd = carry_ff;
            count_in = wptr_ff + 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_v_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The freed entry's write and the first read of entry 0, issued in FIND,
   // land on the same edge, so the registered read may return the old entry.
   // The non-pending first step of MERGE reads entry 0 again after the write
   // has landed, so the merge sees the freed entry.
   logic merge_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         split_min_ff <= 13'd16;
         count_ff     <= ffha_pkg::CntW'(1);
         rd_pend_ff   <= 1'b0;
         rsp_v_ff     <= 1'b0;
         carry_v_ff   <= 1'b0;
         merge_first_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= (state_ff == S_FIND && state_in == S_MERGE) ? 1'b0 : rd_pend_in;
         rsp_v_ff   <= rsp_v_in;
         carry_v_ff <= carry_v_in;
         merge_first_ff <= (state_in == S_MERGE) && (state_ff != S_MERGE);
         if (csr_wr_en) begin
            split_min_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_in_hold: begin
         idx_ff      <= (state_ff == S_FIND && state_in == S_MERGE) ? idx_in :
                        (state_ff == S_MERGE && !rd_pend_ff) ? idx_ff : idx_in;
      end
      wptr_ff     <= wptr_in;
      need_ff     <= need_in;
      off_ff      <= off_in;
      carry_ff    <= carry_in;
      split_ff    <= split_in;
      split_at_ff <= split_at_in;
      rsp_ff      <= rsp_in;
   end

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp.ready |=> rsp_v_ff && $stable(rsp_ff)) else $error("rsp dropped");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= ffha_pkg::CntW'(ffha_pkg::MaxBlocks))
      else $error("count out of range");
   a_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.status != ffha_pkg::ST_ALLOC |-> rsp_ff.grant_offset == '0)
      else $error("grant nonzero");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_merge_first: assert property (@(posedge clock) disable iff (reset)
      merge_first_ff |-> !rd_pend_ff) else $error("merge read too early");
endmodule

/* sv/ffha_ram.sv */
module ffha_ram #(
   parameter int unsigned Depth = 64,
   parameter int unsigned Width = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* verif/tb.sv */
module tb;
   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [12:0] csr_wr_data;

   ffha_req_if req_ch();
   ffha_rsp_if rsp_ch();

   first_fit_heap_allocator u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Shadow of the block table; predicts the status and offset of each transaction.
   class heap_scoreboard;
      logic [23:0] blk_start[ffha_pkg::MaxBlocks];
      logic [24:0] blk_size[ffha_pkg::MaxBlocks];
      bit          blk_free[ffha_pkg::MaxBlocks];
      int          blk_count;
      logic [12:0] split_min;
      ffha_pkg::rsp_type pending[$];
      int          errors;
      int          live_offsets[$];

      function void clear();
         for (int k = 0; k < ffha_pkg::MaxBlocks; k++) begin
            blk_start[k] = '0;
            blk_size[k] = '0;
            blk_free[k] = 0;
         end
         blk_size[0] = 25'(ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes);
         blk_free[0] = 1;
         blk_count = 1;
         split_min = 13'd16;
         errors = 0;
      endfunction

      function void drop_entry(int idx);
         for (int k = idx; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
         end
         blk_count--;
         blk_start[blk_count] = '0;
         blk_size[blk_count] = '0;
         blk_free[blk_count] = 0;
      endfunction

      function void note_request(ffha_pkg::req_type_type r);
         ffha_pkg::rsp_type e;
         longint unsigned need;
         longint unsigned pay;
         int i;
         e.status = ffha_pkg::ST_NOFIT;
         e.grant_offset = '0;
         if (r.req_type == ffha_pkg::REQ_ALLOC) begin
            if (r.req_size == 0) e.status = ffha_pkg::ST_ZERO;
            else if (r.req_size <= ffha_pkg::HeapBytes) begin
               need = ((longint'(r.req_size) + ffha_pkg::AlignBytes - 1)
                       / ffha_pkg::AlignBytes) * ffha_pkg::AlignBytes;
               for (i = 0; i < blk_count; i++) begin
                  if (blk_free[i] && blk_size[i] >= need) begin
                     pay = blk_size[i];
                     if (blk_count < ffha_pkg::MaxBlocks &&
                         pay > need + ffha_pkg::HeaderBytes + split_min) begin
                        for (int k = blk_count; k > i + 1; k--) begin
                           blk_start[k] = blk_start[k-1];
                           blk_size[k] = blk_size[k-1];
                           blk_free[k] = blk_free[k-1];
                        end
                        blk_start[i+1] = 24'(blk_start[i] + ffha_pkg::HeaderBytes + need);
                        blk_size[i+1] = 25'(pay - need - ffha_pkg::HeaderBytes);
                        blk_free[i+1] = 1;
                        blk_count++;
                        blk_size[i] = 25'(need);
                     end
                     blk_free[i] = 0;
                     e.grant_offset = 24'(blk_start[i] + ffha_pkg::HeaderBytes);
                     e.status = ffha_pkg::ST_ALLOC;
                     live_offsets.push_back(e.grant_offset);
                     break;
                  end
               end
            end
         end else begin
            e.status = ffha_pkg::ST_IGNORED;
            for (i = 0; i < blk_count; i++) begin
               if (longint'(blk_start[i]) + ffha_pkg::HeaderBytes == r.free_offset) begin
                  if (!blk_free[i]) begin
                     blk_free[i] = 1;
                     e.status = ffha_pkg::ST_FREED;
                     i = 0;
                     while (i + 1 < blk_count) begin
                        if (blk_free[i] && blk_free[i+1]) begin
                           blk_size[i] = 25'(blk_size[i] + ffha_pkg::HeaderBytes
                                             + blk_size[i+1]);
                           drop_entry(i + 1);
                        end else i++;
                     end
                  end
                  break;
               end
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(ffha_pkg::rsp_type a);
         ffha_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result status=%0d offset=%0h", a.status, a.grant_offset);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, a.status);
            errors++;
         end
         if (a.grant_offset !== e.grant_offset) begin
            $error("grant_offset: expected %0h actual %0h", e.grant_offset, a.grant_offset);
            errors++;
         end
      endfunction
   endclass

   heap_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_rsp;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
         rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Valid stays high after acceptance until the next call or a drain decides.
   task automatic send_item(ffha_pkg::req_type_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic send_alloc(logic [31:0] sz);
      ffha_pkg::req_type_type r;
      r.req_type = ffha_pkg::REQ_ALLOC;
      r.req_size = sz;
      r.free_offset = 24'($urandom);
      send_item(r);
   endtask

   task automatic send_free(logic [23:0] off);
      ffha_pkg::req_type_type r;
      r.req_type = ffha_pkg::REQ_FREE;
      r.req_size = $urandom;
      r.free_offset = off;
      send_item(r);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (2 * ffha_pkg::MaxBlocks + 10) @(posedge clock);
   endtask

   task automatic write_split_min(logic [12:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.split_min = v;
      csr_wr_en <= 1'b0;
   endtask

   // Mostly small allocations, frees of live blocks, a little noise.
   task automatic random_item();
      int pick;
      int idx;
      pick = $urandom_range(99);
      if (pick < 45) begin
         if ($urandom_range(19) == 0) send_alloc($urandom_range(ffha_pkg::HeapBytes, 1));
         else send_alloc($urandom_range(300, 1));
      end else if (pick < 85 && sb.live_offsets.size() > 0) begin
         idx = $urandom_range(sb.live_offsets.size() - 1);
         send_free(24'(sb.live_offsets[idx]));
         sb.live_offsets.delete(idx);
      end else if (pick < 92) begin
         send_free(24'($urandom));
      end else if (pick < 96) begin
         send_alloc($urandom);
      end else begin
         send_alloc(0);
      end
   endtask

   task automatic run_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) random_item();
   endtask

   initial begin
      sb = new();
      sb.clear();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      hold_rsp = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero size, oversize, full heap, all-ones, frees of unknown, double free.
      send_alloc(0);
      send_alloc(ffha_pkg::HeapBytes + 1);
      send_alloc(32'hFFFF_FFFF);
      send_alloc(1);
      send_alloc(8);
      send_alloc(ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes - 100);
      send_free(24'hFF_FFFF);
      send_free(24'd0);
      send_free(24'd12);
      send_free(24'd12);
      send_free(24'd32);
      send_alloc(ffha_pkg::HeapBytes);
      send_free(24'd44);
      send_alloc(ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes);
      send_free(24'd12);
      sb.live_offsets.delete();

      // Split threshold extremes: none and the largest 13-bit value.
      write_split_min(13'd0);
      send_alloc(5);
      send_alloc(13);
      write_split_min(13'h1FFF);
      send_alloc(16);
      send_alloc(100);

      // Fill the table to force whole-block grants.
      write_split_min(13'd16);
      repeat (70) send_alloc($urandom_range(64, 1));
      repeat (40) random_item();

      run_phase(250, 0, 0);
      write_split_min(13'd4096);
      run_phase(250, 54, 0);
      write_split_min(13'd0);
      run_phase(250, 0, 54);
      write_split_min(13'($urandom_range(200)));
      run_phase(250, 35, 35);

      // Long receiver hold-off while the sender keeps pushing.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         run_phase(20, 0, 0);
      join
      drain();
      run_phase(60, 0, 0);

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
